/* hdl/ple_pkg.sv */
package ple_pkg;

   localparam int DEPTH_DEFAULT       = 128;
   localparam int ENTRY_WIDTH_DEFAULT = 32;

   localparam int MODE_W  = 3;
   localparam int WORD_W  = 32;
   localparam int POS_W   = 8;
   localparam int COUNT_W = 8;
   localparam int CAP_W   = 8;

   localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_INSERT     = 3'd2,
      MODE_POP_FRONT  = 3'd3,
      MODE_POP_BACK   = 3'd4,
      MODE_ERASE      = 3'd5,
      MODE_QUERY      = 3'd6,
      MODE_UNUSED     = 3'd7
   } mode_type;

endpackage

/* hdl/ple_if.sv */
interface ple_req_if import ple_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [WORD_W-1:0] entry_word;
   logic [POS_W-1:0]  position;

   modport source (output valid, mode, entry_word, position, input ready);
   modport sink   (input valid, mode, entry_word, position, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               ok;
   logic [WORD_W-1:0]  front_entry;
   logic [WORD_W-1:0]  back_entry;
   logic [COUNT_W-1:0] entry_count;
   logic               is_empty;
   logic               is_full;

   modport source (output valid, ok, front_entry, back_entry, entry_count, is_empty,
                   is_full, input ready);
   modport sink   (input valid, ok, front_entry, back_entry, entry_count, is_empty,
                   is_full, output ready);
endinterface

/* hdl/positional_list_engine.sv */
// Positional list engine: an ordered list of up to DEPTH entries held in linked
// slot memories (payload, next link, previous link) plus a free-slot stack.
// req_bus carries one item (mode, entry_word, position); rsp_bus returns one item
// per request with ok, front/back entries, count, empty and full flags.
// csr_we/csr_wdata write the capacity limit; write only while the block is idle.
// Insert beyond position 1 and erase at an inner position walk the next-link
// memory from the head, one slot per cycle. One item is in flight at a time;
// req_bus.ready is high only when idle, so a new item is taken only once the
// response of the last one has been registered.
// The response sits in an output register; a stalled receiver holds it and the
// block can take and work the next item, finishing once the register frees up.
// Reset (synchronous) empties the list, marks every slot free and sets the
// capacity limit to 100; no memory clearing pass is needed.
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   ple_req_if.sink          req_bus,
   ple_rsp_if.source        rsp_bus,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   localparam int SW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = (CW > 8) ? CW : 8;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DISPATCH = 9'b000000010,
      ST_WALK     = 9'b000000100,
      ST_PEEK     = 9'b000001000,
      ST_ALLOC    = 9'b000010000,
      ST_FETCH    = 9'b000100000,
      ST_LOAD     = 9'b001000000,
      ST_LINK     = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   // memories
   logic [ENTRY_WIDTH-1:0] pay_mem  [DEPTH];
   logic [SW-1:0]          next_mem [DEPTH];
   logic [SW-1:0]          prev_mem [DEPTH];
   logic [SW-1:0]          free_mem [DEPTH];

   logic                   pay_we, next_we, prev_we, free_we;
   logic [SW-1:0]          pay_waddr, next_waddr, prev_waddr, free_waddr;
   logic [ENTRY_WIDTH-1:0] pay_wdata;
   logic [SW-1:0]          next_wdata, prev_wdata, free_wdata;
   logic [SW-1:0]          pay_raddr, next_raddr, prev_raddr, free_raddr;
   logic [ENTRY_WIDTH-1:0] pay_q;
   logic [SW-1:0]          next_q, prev_q, free_q;
   logic [SW-1:0]          free_raddr_ff;

   // control and payload registers
   state_type              state_ff, state_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [ENTRY_WIDTH-1:0] word_ff, word_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [POS_W-1:0]       steps_ff, steps_in;
   logic [SW-1:0]          cur_ff, cur_in;
   logic [SW-1:0]          s_ff, s_in;
   logic [SW-1:0]          pr_ff, pr_in;
   logic [SW-1:0]          head_ff, head_in;
   logic [SW-1:0]          tail_ff, tail_in;
   logic [ENTRY_WIDTH-1:0] head_word_ff, head_word_in;
   logic [ENTRY_WIDTH-1:0] tail_word_ff, tail_word_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          free_top_ff, free_top_in;
   logic [CW-1:0]          min_top_ff, min_top_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic                   ok_ff, ok_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [WORD_W-1:0]      rsp_front_ff, rsp_front_in;
   logic [WORD_W-1:0]      rsp_back_ff, rsp_back_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                   rsp_empty_ff, rsp_empty_in;
   logic                   rsp_full_ff, rsp_full_in;

   // decode helpers
   logic [KW-1:0]          count_ext, cap_ext, pos_ext;
   logic [CW-1:0]          ftop_m1;
   logic [SW-1:0]          free_slot;
   logic                   can_add, pos_bad, pop_f, pop_b, walking_insert;

   assign count_ext = KW'(count_ff);
   assign cap_ext   = KW'(cap_ff);
   assign pos_ext   = KW'(pos_ff);
   assign ftop_m1   = free_top_ff - CW'(1);
   assign can_add   = (count_ext < cap_ext) && (free_top_ff != '0);
   assign pos_bad   = (pos_ff == '0) || (pos_ext > count_ext);
   assign pop_f     = (mode_ff == MODE_POP_FRONT) ||
                      ((mode_ff == MODE_ERASE) && (pos_ff == POS_W'(1)));
   assign pop_b     = (mode_ff == MODE_POP_BACK) ||
                      ((mode_ff == MODE_ERASE) && (pos_ff != POS_W'(1)) &&
                       (pos_ext == count_ext));
   assign walking_insert = (mode_ff == MODE_INSERT);
   // stack entries below the low-water mark were never written: they hold their index
   assign free_slot = (CW'(free_raddr_ff) < min_top_ff) ? free_raddr_ff : free_q;

   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[pay_waddr] <= pay_wdata;
      end
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (free_we) begin
         free_mem[free_waddr] <= free_wdata;
      end
      pay_q         <= pay_mem[pay_raddr];
      next_q        <= next_mem[next_raddr];
      prev_q        <= prev_mem[prev_raddr];
      free_q        <= free_mem[free_raddr];
      free_raddr_ff <= free_raddr;
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      word_in      = word_ff;
      pos_in       = pos_ff;
      steps_in     = steps_ff;
      cur_in       = cur_ff;
      s_in         = s_ff;
      pr_in        = pr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      head_word_in = head_word_ff;
      tail_word_in = tail_word_ff;
      count_in     = count_ff;
      free_top_in  = free_top_ff;
      min_top_in   = min_top_ff;
      cap_in       = csr_we ? csr_wdata : cap_ff;
      ok_in        = ok_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_front_in = rsp_front_ff;
      rsp_back_in  = rsp_back_ff;
      rsp_count_in = rsp_count_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_full_in  = rsp_full_ff;

      pay_we     = 1'b0;
      next_we    = 1'b0;
      prev_we    = 1'b0;
      free_we    = 1'b0;
      pay_waddr  = '0;
      next_waddr = '0;
      prev_waddr = '0;
      free_waddr = free_top_ff[SW-1:0];
      pay_wdata  = word_ff;
      next_wdata = '0;
      prev_wdata = '0;
      free_wdata = '0;
      pay_raddr  = '0;
      next_raddr = '0;
      prev_raddr = '0;
      free_raddr = ftop_m1[SW-1:0];

      req_bus.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               mode_in  = req_bus.mode;
               word_in  = ENTRY_WIDTH'(64'(req_bus.entry_word));
               pos_in   = req_bus.position;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            ok_in    = 1'b0;
            state_in = ST_DONE;
            case (mode_ff)
               MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                  if (can_add) begin
                     state_in = ST_ALLOC;
                  end
               end
               MODE_INSERT: begin
                  if (!pos_bad && can_add) begin
                     if (pos_ff == POS_W'(1)) begin
                        mode_in  = MODE_PUSH_FRONT;
                        state_in = ST_ALLOC;
                     end else begin
                        next_raddr = head_ff;
                        steps_in   = POS_W'(1);
                        state_in   = ST_WALK;
                     end
                  end
               end
               MODE_POP_FRONT, MODE_POP_BACK, MODE_ERASE: begin
                  if (count_ff == '0 || (mode_ff == MODE_ERASE && pos_bad)) begin
                     state_in = ST_DONE;
                  end else if (pop_f || pop_b) begin
                     ok_in      = 1'b1;
                     free_we    = (free_top_ff < CW'(DEPTH));
                     free_wdata = pop_f ? head_ff : tail_ff;
                     free_top_in = free_top_ff + CW'(1);
                     count_in   = count_ff - CW'(1);
                     if (count_ff == CW'(1)) begin
                        head_in = '0;
                        tail_in = '0;
                     end else begin
                        next_raddr = head_ff;
                        prev_raddr = tail_ff;
                        mode_in    = pop_f ? MODE_POP_FRONT : MODE_POP_BACK;
                        state_in   = ST_FETCH;
                     end
                  end else begin
                     next_raddr = head_ff;
                     steps_in   = POS_W'(1);
                     state_in   = ST_WALK;
                  end
               end
               MODE_QUERY: begin
                  ok_in = 1'b1;
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end

         ST_WALK: begin
            if (steps_ff == pos_ff - POS_W'(1)) begin
               cur_in     = next_q;
               prev_raddr = next_q;
               next_raddr = next_q;
               state_in   = ST_PEEK;
            end else begin
               next_raddr = next_q;
               steps_in   = steps_ff + POS_W'(1);
            end
         end

         ST_PEEK: begin
            if (walking_insert) begin
               s_in        = free_slot;
               pr_in       = prev_q;
               pay_we      = 1'b1;
               pay_waddr   = free_slot;
               next_we     = 1'b1;
               next_waddr  = prev_q;
               next_wdata  = free_slot;
               prev_we     = 1'b1;
               prev_waddr  = cur_ff;
               prev_wdata  = free_slot;
               free_top_in = ftop_m1;
               if (ftop_m1 < min_top_ff) begin
                  min_top_in = ftop_m1;
               end
               count_in    = count_ff + CW'(1);
               state_in    = ST_LINK;
            end else begin
               next_we     = 1'b1;
               next_waddr  = prev_q;
               next_wdata  = next_q;
               prev_we     = 1'b1;
               prev_waddr  = next_q;
               prev_wdata  = prev_q;
               free_we     = (free_top_ff < CW'(DEPTH));
               free_wdata  = cur_ff;
               free_top_in = free_top_ff + CW'(1);
               count_in    = count_ff - CW'(1);
               ok_in       = 1'b1;
               state_in    = ST_DONE;
            end
         end

         ST_LINK: begin
            next_we    = 1'b1;
            next_waddr = s_ff;
            next_wdata = cur_ff;
            prev_we    = 1'b1;
            prev_waddr = s_ff;
            prev_wdata = pr_ff;
            ok_in      = 1'b1;
            state_in   = ST_DONE;
         end

         ST_ALLOC: begin
            pay_we      = 1'b1;
            pay_waddr   = free_slot;
            free_top_in = ftop_m1;
            if (ftop_m1 < min_top_ff) begin
               min_top_in = ftop_m1;
            end
            count_in    = count_ff + CW'(1);
            if (count_ff == '0) begin
               head_in      = free_slot;
               tail_in      = free_slot;
               head_word_in = word_ff;
               tail_word_in = word_ff;
            end else if (mode_ff == MODE_PUSH_FRONT) begin
               next_we      = 1'b1;
               next_waddr   = free_slot;
               next_wdata   = head_ff;
               prev_we      = 1'b1;
               prev_waddr   = head_ff;
               prev_wdata   = free_slot;
               head_in      = free_slot;
               head_word_in = word_ff;
            end else begin
               prev_we      = 1'b1;
               prev_waddr   = free_slot;
               prev_wdata   = tail_ff;
               next_we      = 1'b1;
               next_waddr   = tail_ff;
               next_wdata   = free_slot;
               tail_in      = free_slot;
               tail_word_in = word_ff;
            end
            ok_in    = 1'b1;
            state_in = ST_DONE;
         end

         ST_FETCH: begin
            if (mode_ff == MODE_POP_FRONT) begin
               head_in   = next_q;
               pay_raddr = next_q;
            end else begin
               tail_in   = prev_q;
               pay_raddr = prev_q;
            end
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            if (mode_ff == MODE_POP_FRONT) begin
               head_word_in = pay_q;
            end else begin
               tail_word_in = pay_q;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_front_in = (count_ff != '0) ? WORD_W'(head_word_ff) : '0;
               rsp_back_in  = (count_ff != '0) ? WORD_W'(tail_word_ff) : '0;
               rsp_count_in = count_ext[COUNT_W-1:0];
               rsp_empty_in = (count_ff == '0);
               rsp_full_in  = (count_ext == cap_ext);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         free_top_ff  <= CW'(DEPTH);
         min_top_ff   <= CW'(DEPTH);
         cap_ff       <= CAP_RESET;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         free_top_ff  <= free_top_in;
         min_top_ff   <= min_top_in;
         cap_ff       <= cap_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      word_ff      <= word_in;
      pos_ff       <= pos_in;
      steps_ff     <= steps_in;
      cur_ff       <= cur_in;
      s_ff         <= s_in;
      pr_ff        <= pr_in;
      head_word_ff <= head_word_in;
      tail_word_ff <= tail_word_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_front_ff <= rsp_front_in;
      rsp_back_ff  <= rsp_back_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.ok          = rsp_ok_ff;
   assign rsp_bus.front_entry = rsp_front_ff;
   assign rsp_bus.back_entry  = rsp_back_ff;
   assign rsp_bus.entry_count = rsp_count_ff;
   assign rsp_bus.is_empty    = rsp_empty_ff;
   assign rsp_bus.is_full     = rsp_full_ff;

endmodule

/* tb/positional_list_engine_tb.sv */
module positional_list_engine_tb
   import ple_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;

   typedef struct packed {
      logic              ok;
      logic [WORD_W-1:0] front_entry;
      logic [WORD_W-1:0] back_entry;
      logic [COUNT_W-1:0] entry_count;
      logic              is_empty;
      logic              is_full;
   } list_status_type;

   typedef struct {
      mode_type          mode;
      logic [WORD_W-1:0] word;
      logic [POS_W-1:0]  pos;
      bit                typed;
      list_status_type   status;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CAP_W-1:0] csr_wdata = '0;

   ple_req_if req_bus ();
   ple_rsp_if rsp_bus ();

   positional_list_engine DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // list image: plain ordered array of payloads
   logic [WORD_W-1:0] list_image[$];
   int unsigned cap_shadow;
   list_status_type expected_status[$];
   int error_count = 0;
   int accepted_items = 0;
   int checked_items = 0;
   int idle_cycles = 0;
   bit stall_rsp = 0;
   bit no_idle = 0;
   bit timed_out = 0;

   function automatic list_status_type apply_op(mode_type m, logic [WORD_W-1:0] w,
                                                logic [POS_W-1:0] pos);
      list_status_type s;
      bit can_add;
      int unsigned n;
      int unsigned p;
      n = list_image.size();
      p = 32'(pos);
      can_add = (n < cap_shadow) && (n < DEPTH_DEFAULT);
      s.ok = 1'b0;
      case (m)
         MODE_PUSH_FRONT: if (can_add) begin list_image.insert(0, w); s.ok = 1'b1; end
         MODE_PUSH_BACK:  if (can_add) begin list_image.insert(n, w); s.ok = 1'b1; end
         MODE_INSERT: if (p != 0 && p <= n && can_add) begin
            list_image.insert(p - 1, w); s.ok = 1'b1;
         end
         MODE_POP_FRONT: if (n != 0) begin list_image.delete(0); s.ok = 1'b1; end
         MODE_POP_BACK:  if (n != 0) begin list_image.delete(n - 1); s.ok = 1'b1; end
         MODE_ERASE: if (p != 0 && p <= n) begin list_image.delete(p - 1); s.ok = 1'b1; end
         MODE_QUERY: s.ok = 1'b1;
         default: s.ok = 1'b0;
      endcase
      n = list_image.size();
      s.front_entry = n ? list_image[0] : '0;
      s.back_entry  = n ? list_image[n-1] : '0;
      s.entry_count = n[COUNT_W-1:0];
      s.is_empty    = (n == 0);
      s.is_full     = (n == cap_shadow);
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("mismatch item %0d %s: got %0h want %0h", checked_items, what, got, want);
   endtask

   // result side
   always @(posedge clock) begin
      list_status_type g, e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         g = '{rsp_bus.ok, rsp_bus.front_entry, rsp_bus.back_entry,
               rsp_bus.entry_count, rsp_bus.is_empty, rsp_bus.is_full};
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected item", 64'(g.entry_count), '0);
         end else begin
            e = expected_status[0];
            expected_status.delete(0);
            if (g.ok != e.ok) report_mismatch("ok", 64'(g.ok), 64'(e.ok));
            if (g.front_entry != e.front_entry)
               report_mismatch("front_entry", 64'(g.front_entry), 64'(e.front_entry));
            if (g.back_entry != e.back_entry)
               report_mismatch("back_entry", 64'(g.back_entry), 64'(e.back_entry));
            if (g.entry_count != e.entry_count)
               report_mismatch("entry_count", 64'(g.entry_count), 64'(e.entry_count));
            if (g.is_empty != e.is_empty)
               report_mismatch("is_empty", 64'(g.is_empty), 64'(e.is_empty));
            if (g.is_full != e.is_full)
               report_mismatch("is_full", 64'(g.is_full), 64'(e.is_full));
         end
         checked_items++;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= !stall_rsp && (no_idle || $urandom_range(99) >= 18);
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_item(mode_type m, logic [WORD_W-1:0] w, logic [POS_W-1:0] p);
      while (!no_idle && $urandom_range(99) < 18) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.mode = m;
      req_bus.entry_word = w;
      req_bus.position = p;
      expected_status.insert(expected_status.size(), apply_op(m, w, p));
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      accepted_items++;
      @(negedge clock);
   endtask

   task automatic send_and_release(mode_type m, logic [WORD_W-1:0] w, logic [POS_W-1:0] p);
      send_item(m, w, p);
      req_bus.valid = 1'b0;
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] v);
      req_bus.valid = 1'b0;
      while (expected_status.size() != 0) @(negedge clock);
      repeat (DEPTH_DEFAULT + 10) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      cap_shadow = 32'(v);
   endtask

   function automatic logic [POS_W-1:0] pick_pos();
      int unsigned n, r;
      n = list_image.size();
      r = $urandom_range(99);
      if (r < 8) return '0;
      if (r < 16) return POS_W'(n + 1 + $urandom_range(3));
      if (r < 22) return 8'hFF - POS_W'($urandom_range(1));
      if (r < 30) return POS_W'(1);
      if (r < 38) return POS_W'(n);
      return POS_W'($urandom_range(n > 1 ? n : 1, 1));
   endfunction

   task automatic random_phase(int items, int add_bias);
      mode_type m;
      int r;
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(99);
         if (r < add_bias) m = mode_type'($urandom_range(2));
         else if (r < 97) m = mode_type'($urandom_range(6, 3));
         else m = MODE_UNUSED;
         send_item(m, $urandom, pick_pos());
      end
      req_bus.valid = 1'b0;
   endtask

   stim_row_type directed_rows[$];
   list_status_type st_empty_refused, st_empty_ok;

   initial begin
      int wait_cycles;
      stim_row_type row;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_QUERY;
      req_bus.entry_word = '0;
      req_bus.position = '0;
      cap_shadow = 32'(CAP_RESET);
      st_empty_refused = '{1'b0, '0, '0, '0, 1'b1, 1'b0};
      st_empty_ok      = '{1'b1, '0, '0, '0, 1'b1, 1'b0};

      directed_rows = '{
         '{MODE_QUERY,      32'h0,        8'd0,   1'b1, st_empty_ok},
         '{MODE_POP_FRONT,  32'h0,        8'd0,   1'b1, st_empty_refused},
         '{MODE_POP_BACK,   32'h0,        8'd0,   1'b1, st_empty_refused},
         '{MODE_ERASE,      32'h0,        8'd1,   1'b1, st_empty_refused},
         '{MODE_INSERT,     32'h1234,     8'd1,   1'b1, st_empty_refused},
         '{MODE_UNUSED,     32'hFFFFFFFF, 8'hFF,  1'b1, st_empty_refused},
         '{MODE_PUSH_BACK,  32'hFFFFFFFF, 8'hFF,  1'b1,
           '{1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd1, 1'b0, 1'b0}},
         '{MODE_PUSH_FRONT, 32'h0,        8'd0,   1'b0, '0},
         '{MODE_PUSH_BACK,  32'hA5A5A5A5, 8'd0,   1'b0, '0},
         '{MODE_INSERT,     32'h11111111, 8'd1,   1'b0, '0},
         '{MODE_INSERT,     32'h22222222, 8'd3,   1'b0, '0},
         '{MODE_INSERT,     32'h33333333, 8'd5,   1'b0, '0},
         '{MODE_INSERT,     32'h44444444, 8'd7,   1'b0, '0},
         '{MODE_INSERT,     32'h55555555, 8'd0,   1'b0, '0},
         '{MODE_ERASE,      32'h0,        8'd0,   1'b0, '0},
         '{MODE_ERASE,      32'h0,        8'd9,   1'b0, '0},
         '{MODE_ERASE,      32'h0,        8'd3,   1'b0, '0},
         '{MODE_ERASE,      32'h0,        8'd1,   1'b0, '0},
         '{MODE_ERASE,      32'h0,        8'd4,   1'b0, '0},
         '{MODE_UNUSED,     32'h0,        8'd1,   1'b0, '0},
         '{MODE_QUERY,      32'h0,        8'h80,  1'b0, '0},
         '{MODE_POP_FRONT,  32'h0,        8'd0,   1'b0, '0},
         '{MODE_POP_BACK,   32'h0,        8'd0,   1'b0, '0},
         '{MODE_POP_BACK,   32'h0,        8'd0,   1'b0, '0}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_item(row.mode, row.word, row.pos);
         if (row.typed && expected_status[$] != row.status) begin
            report_mismatch($sformatf("directed row %0d table", i),
                            64'(expected_status[$].entry_count),
                            64'(row.status.entry_count));
         end
         if (row.typed) expected_status[$] = row.status;
      end
      req_bus.valid = 1'b0;

      // long stretch without idling, then receiver hold-off while the sender keeps going
      no_idle = 1;
      random_phase(150, 60);
      fork
         begin
            stall_rsp = 1;
            wait_cycles = 0;
            while (wait_cycles < 400) begin
               @(negedge clock);
               wait_cycles++;
            end
            stall_rsp = 0;
         end
         random_phase(30, 50);
      join
      no_idle = 0;
      random_phase(300, 55);

      set_capacity(8'd0);
      random_phase(60, 60);
      set_capacity(8'd128);
      random_phase(350, 80);
      random_phase(150, 30);
      set_capacity(8'd5);
      random_phase(200, 60);
      set_capacity(8'd255);
      random_phase(150, 60);
      set_capacity(8'd1);
      random_phase(60, 60);
      set_capacity(8'd40);
      random_phase(100, 55);

      while (expected_status.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("%0d items sent, %0d results checked", accepted_items, checked_items);
      $display("covered all modes, refusals, full list, long receiver stall, limits 0 to 255");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
